// ===== hdl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and the CORDIC arctangent table for the stabilizer.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int CordicStepsDef = 16;
  localparam int TimerBitsDef   = 16;
  localparam int MaxSteps       = 24;
  localparam int QueueDepth     = 2;

  // Datapath width for the CORDIC: inputs up to 2^24, growth about 1.65x.
  localparam int CW = 28;

  localparam logic [1:0] CFG_YAW_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_YAW_HOLD      = 2'd1;
  localparam logic [1:0] CFG_ALERT         = 2'd2;
  localparam logic [1:0] CFG_ALERT_REST    = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ALERT = 2'd1,
    PH_REST  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_SQRT  = 3'd1,
    BK_ROLL  = 3'd2,
    BK_PITCH = 3'd3,
    BK_OUT   = 3'd4
  } bk_state_t;

  // One queued word from the front end.
  typedef struct packed {
    logic        op;
    logic        motion;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] yaw_rate;
  } item_t;

  function automatic logic signed [15:0] atan_q8(input logic [4:0] i);
    case (i)
      5'd0:  atan_q8 = 16'sd11520;
      5'd1:  atan_q8 = 16'sd6801;
      5'd2:  atan_q8 = 16'sd3593;
      5'd3:  atan_q8 = 16'sd1824;
      5'd4:  atan_q8 = 16'sd916;
      5'd5:  atan_q8 = 16'sd458;
      5'd6:  atan_q8 = 16'sd229;
      5'd7:  atan_q8 = 16'sd115;
      5'd8:  atan_q8 = 16'sd57;
      5'd9:  atan_q8 = 16'sd29;
      5'd10: atan_q8 = 16'sd14;
      5'd11: atan_q8 = 16'sd7;
      5'd12: atan_q8 = 16'sd4;
      5'd13: atan_q8 = 16'sd2;
      5'd14: atan_q8 = 16'sd1;
      default: atan_q8 = 16'sd0;
    endcase
  endfunction

endpackage

// ===== hdl/tts_front.sv =====
// ----------------------------------------------------------------------------
// tts_front
// Input stage: accepts words and queues them for the back end.
// ----------------------------------------------------------------------------
module tts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tts_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output tts_pkg::item_t q_item
);

  tts_pkg::item_t mem_r [tts_pkg::QueueDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/tts_cordic.sv =====
// ----------------------------------------------------------------------------
// tts_cordic
// Iterative CORDIC vectoring unit: atan2(num, den) in degrees times 256.
// ----------------------------------------------------------------------------
module tts_cordic #(
  parameter int CORDIC_STEPS = tts_pkg::CordicStepsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [tts_pkg::CW-1:0] num,
  input  logic signed [tts_pkg::CW-1:0] den,
  output logic                        done,
  output logic signed [17:0]          angle
);

  localparam int NSTEPS = (CORDIC_STEPS < tts_pkg::MaxSteps) ? CORDIC_STEPS
                                                            : tts_pkg::MaxSteps;

  logic signed [tts_pkg::CW-1:0] x_r, y_r;
  logic signed [17:0]            ang_r;
  logic [4:0]                    i_r;
  logic                          busy_r, done_r;

  assign done  = done_r;
  assign angle = ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= 5'd0;
        if (den == '0 && num == '0) begin
          ang_r  <= '0;
          done_r <= 1'b1;
        end else if (den < 0) begin
          x_r    <= -den;
          y_r    <= -num;
          ang_r  <= (num >= 0) ? 18'sd46080 : -18'sd46080;
          busy_r <= 1'b1;
        end else begin
          x_r    <= den;
          y_r    <= num;
          ang_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r   <= x_r + (y_r >>> i_r);
          y_r   <= y_r - (x_r >>> i_r);
          ang_r <= ang_r + 18'(tts_pkg::atan_q8(i_r));
        end else begin
          x_r   <= x_r - (y_r >>> i_r);
          y_r   <= y_r + (x_r >>> i_r);
          ang_r <= ang_r - 18'(tts_pkg::atan_q8(i_r));
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(NSTEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/tts_back.sv =====
// ----------------------------------------------------------------------------
// tts_back
// Executes queued words: timers, alert sequence, yaw logic and the tilt math.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int CORDIC_STEPS = tts_pkg::CordicStepsDef,
  parameter int TIMER_BITS   = tts_pkg::TimerBitsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  tts_pkg::item_t q_item,
  input  logic [14:0]    yaw_threshold,
  input  logic [15:0]    yaw_hold_ms,
  input  logic [15:0]    alert_ms,
  input  logic [15:0]    alert_rest_ms,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_roll_servo,
  output logic [7:0]     out_pitch_servo,
  output logic [7:0]     out_yaw_servo,
  output logic           out_alerting
);

  localparam int TB = TIMER_BITS;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};

  // The load marker sits one bit above the first even weight, so the
  // square root's shift sequence never reaches it.
  localparam logic [47:0] SqTop  = 48'd1 << 46;
  localparam logic [47:0] SqLoad = 48'd1 << 47;

  tts_pkg::bk_state_t st_r, st_nxt;
  tts_pkg::phase_t    ph_r;
  logic [TB-1:0] yaw_el_r, rem_r;
  logic          yaw_act_r;
  logic [7:0]    roll_r, pitch_r, yaw_r;
  logic          ov_r;
  tts_pkg::item_t it_r;

  // Bit-serial square root of (y^2+z^2)<<16, one result bit per cycle.
  logic [47:0] sq_v_r, sq_r_r, sq_b_r;

  logic                          c_start, c_done;
  logic signed [tts_pkg::CW-1:0] c_num, c_den;
  logic signed [17:0]            c_ang;

  tts_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .num(c_num), .den(c_den),
    .done(c_done), .angle(c_ang)
  );

  logic running;
  assign running = (ph_r == tts_pkg::PH_ALERT) || (ph_r == tts_pkg::PH_REST);

  logic signed [16:0] rate_s, mag_s;
  assign rate_s = 17'(signed'(it_r.yaw_rate));
  assign mag_s  = (rate_s < 0) ? -rate_s : rate_s;

  logic signed [31:0] y2, z2;
  assign y2 = signed'(it_r.accel_y) * signed'(it_r.accel_y);
  assign z2 = signed'(it_r.accel_z) * signed'(it_r.accel_z);

  // Whole-degree truncation of the clamped CORDIC angle.
  function automatic logic signed [7:0] whole(input logic signed [17:0] q);
    logic signed [17:0] c;
    logic [17:0]        a;
    c = q;
    if (c > 18'sd23040) c = 18'sd23040;
    if (c < -18'sd23040) c = -18'sd23040;
    a = (c < 0) ? 18'(-c) : 18'(c);
    whole = (c < 0) ? -8'(a[17:8]) : 8'(a[17:8]);
  endfunction

  logic [TB-1:0] ld_alert, ld_rest;
  assign ld_alert = (TB >= 16) ? TB'(alert_ms) :
                    ((alert_ms > 16'(TMAX)) ? TMAX : TB'(alert_ms));
  assign ld_rest  = (TB >= 16) ? TB'(alert_rest_ms) :
                    ((alert_rest_ms > 16'(TMAX)) ? TMAX : TB'(alert_rest_ms));

  logic issue;
  assign issue = (st_r == tts_pkg::BK_IDLE) && q_valid && (!ov_r || out_ready);
  assign q_pop = issue;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tts_pkg::BK_IDLE: begin
        if (issue && !q_item.op && !running && !q_item.motion) st_nxt = tts_pkg::BK_SQRT;
      end
      tts_pkg::BK_SQRT:  if (sq_b_r == '0) st_nxt = tts_pkg::BK_ROLL;
      tts_pkg::BK_ROLL:  if (c_done) st_nxt = tts_pkg::BK_PITCH;
      tts_pkg::BK_PITCH: if (c_done) st_nxt = tts_pkg::BK_OUT;
      tts_pkg::BK_OUT:   if (!ov_r || out_ready) st_nxt = tts_pkg::BK_IDLE;
      default: st_nxt = tts_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    c_start = 1'b0;
    c_num   = '0;
    c_den   = '0;
    if (st_r == tts_pkg::BK_SQRT && sq_b_r == '0) begin
      c_start = 1'b1;
      c_num   = tts_pkg::CW'(signed'(it_r.accel_y)) <<< 8;
      c_den   = tts_pkg::CW'(signed'(it_r.accel_z)) <<< 8;
    end else if (st_r == tts_pkg::BK_ROLL && c_done) begin
      c_start = 1'b1;
      c_num   = -(tts_pkg::CW'(signed'(it_r.accel_x)) <<< 8);
      c_den   = tts_pkg::CW'(sq_r_r);
    end
  end

  assign out_roll_servo  = roll_r;
  assign out_pitch_servo = pitch_r;
  assign out_yaw_servo   = yaw_r;
  assign out_alerting    = running;
  assign out_valid       = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tts_pkg::BK_IDLE;
      ph_r      <= tts_pkg::PH_IDLE;
      yaw_el_r  <= '0;
      rem_r     <= '0;
      yaw_act_r <= 1'b0;
      roll_r    <= 8'd90;
      pitch_r   <= 8'd90;
      yaw_r     <= 8'd90;
      ov_r      <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (issue) begin
        it_r <= q_item;
        if (q_item.op) begin
          if (yaw_el_r != TMAX) yaw_el_r <= yaw_el_r + 1'b1;
          if (running) begin
            if (rem_r <= TB'(1)) begin
              if (ph_r == tts_pkg::PH_ALERT) begin
                ph_r    <= tts_pkg::PH_REST;
                rem_r   <= ld_rest;
                roll_r  <= 8'd90;
                pitch_r <= 8'd90;
                yaw_r   <= 8'd90;
              end else begin
                ph_r  <= tts_pkg::PH_IDLE;
                rem_r <= '0;
              end
            end else begin
              rem_r <= rem_r - 1'b1;
            end
          end
          ov_r <= 1'b1;
        end else if (running) begin
          ov_r <= 1'b1;
        end else if (q_item.motion) begin
          ph_r    <= tts_pkg::PH_ALERT;
          rem_r   <= ld_alert;
          roll_r  <= 8'd180;
          pitch_r <= 8'd180;
          yaw_r   <= 8'd180;
          ov_r    <= 1'b1;
        end else begin
          sq_b_r <= '0;
        end
      end
      if (st_r == tts_pkg::BK_IDLE && st_nxt == tts_pkg::BK_SQRT) begin
        sq_b_r <= SqLoad;
        sq_r_r <= '0;
      end else if (st_r == tts_pkg::BK_SQRT) begin
        if (sq_b_r == SqLoad) begin
          sq_v_r <= 48'(unsigned'(y2) + unsigned'(z2)) << 16;
          sq_b_r <= SqTop;
        end else if (sq_b_r != '0) begin
          if (sq_v_r >= sq_r_r + sq_b_r) begin
            sq_v_r <= sq_v_r - (sq_r_r + sq_b_r);
            sq_r_r <= (sq_r_r >> 1) + sq_b_r;
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_b_r <= sq_b_r >> 2;
        end
      end
      if (st_r == tts_pkg::BK_ROLL && c_done) roll_r <= 8'(9'sd90 - 9'(whole(c_ang)));
      if (st_r == tts_pkg::BK_PITCH && c_done) begin
        pitch_r <= 8'(9'sd90 + 9'(whole(c_ang)));
        if (mag_s > 17'(yaw_threshold)) begin
          yaw_r     <= (rate_s > 0) ? 8'd135 : 8'd45;
          yaw_act_r <= 1'b1;
          yaw_el_r  <= '0;
        end else if (yaw_act_r) begin
          if (32'(yaw_el_r) < 32'(yaw_hold_ms)) begin
            yaw_r <= (rate_s > 0) ? 8'd135 : 8'd45;
          end else begin
            yaw_r     <= 8'd90;
            yaw_act_r <= 1'b0;
          end
        end else begin
          yaw_r <= 8'd90;
        end
      end
      if (st_r == tts_pkg::BK_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
    end
  end

endmodule

// ===== hdl/tilt_to_servo_stabilizer.sv =====
// ----------------------------------------------------------------------------
// tilt_to_servo_stabilizer
// Accelerometer tilt to servo angle converter with yaw hold and motion alert.
// ----------------------------------------------------------------------------
// Every accepted word yields one result word. Ticks, ignored samples and
// motion samples load the result register at issue. A tilt sample passes
// through the issue, the bit-serial square root, two runs on the shared
// CORDIC unit (CORDIC_STEPS capped at 24), the output state and the
// handshake. A result that is not taken holds the back end. A two-word
// queue lets the input side keep accepting while the back end works.
module tilt_to_servo_stabilizer #(
  parameter int CORDIC_STEPS = tts_pkg::CordicStepsDef,
  parameter int TIMER_BITS   = tts_pkg::TimerBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic        in_motion,
  input  logic [15:0] in_accel_x,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  input  logic [15:0] in_yaw_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_roll_servo,
  output logic [7:0]  out_pitch_servo,
  output logic [7:0]  out_yaw_servo,
  output logic        out_alerting,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [14:0] thr_r;
  logic [15:0] hold_r, alert_r, rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 15'd983;
      hold_r  <= 16'd1000;
      alert_r <= 16'd1500;
      rest_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        tts_pkg::CFG_YAW_THRESHOLD: thr_r   <= cfg_data[14:0];
        tts_pkg::CFG_YAW_HOLD:      hold_r  <= cfg_data;
        tts_pkg::CFG_ALERT:         alert_r <= cfg_data;
        tts_pkg::CFG_ALERT_REST:    rest_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tts_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;
  assign in_item = '{op: in_op, motion: in_motion, accel_x: in_accel_x,
                     accel_y: in_accel_y, accel_z: in_accel_z, yaw_rate: in_yaw_rate};

  tts_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  tts_back #(.CORDIC_STEPS(CORDIC_STEPS), .TIMER_BITS(TIMER_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .yaw_threshold(thr_r), .yaw_hold_ms(hold_r), .alert_ms(alert_r),
    .alert_rest_ms(rest_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_servo(out_roll_servo), .out_pitch_servo(out_pitch_servo),
    .out_yaw_servo(out_yaw_servo), .out_alerting(out_alerting)
  );

endmodule
